// ----- rtl/sso_pkg.sv -----
// Shared types, constants and helper functions of the sweep sonar obstacle avoider.
`timescale 1ns / 1ps
package sso_pkg;

    localparam int unsigned SSO_QUEUE_DEPTH = 4;

    localparam int unsigned SPEED_W  = 13;
    localparam int unsigned ANGLE_W  = 8;
    localparam int unsigned HOLD_W   = 10;
    localparam int unsigned DIST_W   = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_A_W  = 3;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 72;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_TICK_PERIOD    = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_FRONT_NEAR     = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_SIDE_NEAR      = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_SIDE_VERY_NEAR = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_BACKOFF        = 3'd4;

    localparam logic [CFG_W-1:0]  RST_TICK_PERIOD    = 16'd200;
    localparam logic [CFG_W-1:0]  RST_FRONT_NEAR     = 16'd480;
    localparam logic [CFG_W-1:0]  RST_SIDE_NEAR      = 16'd320;
    localparam logic [CFG_W-1:0]  RST_SIDE_VERY_NEAR = 16'd160;
    localparam logic [HOLD_W-1:0] RST_BACKOFF        = 10'd100;
    localparam logic [DIST_W-1:0] RST_DISTANCE       = 16'd480;

    // Sweep slots
    localparam logic [1:0] POS_LEFT   = 2'd0;
    localparam logic [1:0] POS_CENTRE = 2'd1;
    localparam logic [1:0] POS_RIGHT  = 2'd2;

    localparam logic [ANGLE_W-1:0] ANGLE_LEFT   = 8'd30;
    localparam logic [ANGLE_W-1:0] ANGLE_CENTRE = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_RIGHT  = 8'd150;

    localparam logic signed [SPEED_W-1:0] SPD_TURN      = 13'sd1450;
    localparam logic signed [SPEED_W-1:0] SPD_TURN_N    = -13'sd1450;
    localparam logic signed [SPEED_W-1:0] SPD_SPIN      = 13'sd1500;
    localparam logic signed [SPEED_W-1:0] SPD_SPIN_N    = -13'sd1500;
    localparam logic signed [SPEED_W-1:0] SPD_SPIN_IN_N = -13'sd1000;
    localparam logic signed [SPEED_W-1:0] SPD_VEER      = 13'sd2000;
    localparam logic signed [SPEED_W-1:0] SPD_VEER_IN_N = -13'sd500;
    localparam logic signed [SPEED_W-1:0] SPD_CRUISE    = 13'sd600;

    // Command classes decided by the front end
    typedef enum logic [2:0] {
        CMD_BACK_TURN_RIGHT,
        CMD_BACK_TURN_LEFT,
        CMD_SPIN_RIGHT,
        CMD_VEER_RIGHT,
        CMD_SPIN_LEFT,
        CMD_VEER_LEFT,
        CMD_CRUISE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [ANGLE_W-1:0] angle;
        logic [HOLD_W-1:0]  hold;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0]  tick_period;
        logic [CFG_W-1:0]  front_near;
        logic [CFG_W-1:0]  side_near;
        logic [CFG_W-1:0]  side_very_near;
        logic [HOLD_W-1:0] backoff;
    } cfg_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] rb;
        logic signed [SPEED_W-1:0] rf;
        logic signed [SPEED_W-1:0] lb;
        logic signed [SPEED_W-1:0] lf;
    } wheels_t;

    function automatic logic [ANGLE_W-1:0] angle_of(input logic [1:0] pos);
        logic [ANGLE_W-1:0] a;
        case (pos)
            POS_LEFT:   a = ANGLE_LEFT;
            POS_CENTRE: a = ANGLE_CENTRE;
            default:    a = ANGLE_RIGHT;
        endcase
        return a;
    endfunction

    function automatic logic is_two(input cmd_kind_t k);
        return (k == CMD_BACK_TURN_RIGHT) || (k == CMD_BACK_TURN_LEFT);
    endfunction

    function automatic wheels_t wheels_of(input cmd_kind_t k, input logic second);
        wheels_t w;
        case (k)
            CMD_BACK_TURN_RIGHT: begin
                if (second) w = '{rb: SPD_TURN_N, rf: SPD_TURN_N, lb: SPD_TURN, lf: SPD_TURN};
                else        w = '{rb: SPD_TURN_N, rf: SPD_TURN_N, lb: SPD_TURN_N, lf: SPD_TURN_N};
            end
            CMD_BACK_TURN_LEFT: begin
                if (second) w = '{rb: SPD_TURN, rf: SPD_TURN, lb: SPD_TURN_N, lf: SPD_TURN_N};
                else        w = '{rb: SPD_TURN_N, rf: SPD_TURN_N, lb: SPD_TURN_N, lf: SPD_TURN_N};
            end
            CMD_SPIN_RIGHT: w = '{rb: SPD_SPIN_IN_N, rf: SPD_SPIN_IN_N, lb: SPD_SPIN, lf: SPD_SPIN};
            CMD_VEER_RIGHT: w = '{rb: SPD_VEER_IN_N, rf: SPD_VEER_IN_N, lb: SPD_VEER, lf: SPD_VEER};
            CMD_SPIN_LEFT:  w = '{rb: SPD_SPIN, rf: SPD_SPIN, lb: SPD_SPIN_N, lf: SPD_SPIN_N};
            CMD_VEER_LEFT:  w = '{rb: SPD_VEER, rf: SPD_VEER, lb: SPD_VEER_IN_N, lf: SPD_VEER_IN_N};
            default:        w = '{rb: SPD_CRUISE, rf: SPD_CRUISE, lb: SPD_CRUISE, lf: SPD_CRUISE};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/sso_front.sv -----
// Front end: tick gating, distance slots, servo sweep and command classification.
`timescale 1ns / 1ps
module sso_front
    import sso_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TIME_W-1:0] s_now,
    input  logic [DIST_W-1:0] s_dist,
    input  cfg_t              cfg,
    input  logic              q_full,
    output logic              push,
    output cmd_t              push_cmd
);

    logic [TIME_W-1:0] last_tick_reg, last_tick_next;
    logic [1:0]        pos_reg, pos_next;
    logic              up_reg, up_next;
    logic [DIST_W-1:0] dist_reg [3];
    logic [DIST_W-1:0] dl, dc, dr;
    logic [TIME_W-1:0] elapsed;
    logic [1:0]        slot;
    logic              take;
    cmd_kind_t         kind;

    assign s_tready = !q_full;
    assign elapsed  = s_now - last_tick_reg;
    assign take     = elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.tick_period};
    assign push     = s_tvalid && s_tready && take;

    always_comb begin
        // Position three never occurs; treat it as the right slot.
        slot = (pos_reg == POS_LEFT || pos_reg == POS_CENTRE) ? pos_reg : POS_RIGHT;
        if (slot == POS_LEFT)       up_next = 1'b1;
        else if (slot == POS_RIGHT) up_next = 1'b0;
        else                        up_next = up_reg;
        pos_next       = up_next ? slot + 2'd1 : slot - 2'd1;
        last_tick_next = s_now;

        // Slots as they stand after this reading is stored
        dl = (slot == POS_LEFT)   ? s_dist : dist_reg[0];
        dc = (slot == POS_CENTRE) ? s_dist : dist_reg[1];
        dr = (slot == POS_RIGHT)  ? s_dist : dist_reg[2];

        // Centre near shadows the two "side and centre near" cases.
        if (dc < cfg.front_near)
            kind = (dl < dr) ? CMD_BACK_TURN_RIGHT : CMD_BACK_TURN_LEFT;
        else if (dl < cfg.side_near)
            kind = (dl < cfg.side_very_near) ? CMD_SPIN_RIGHT : CMD_VEER_RIGHT;
        else if (dr < cfg.side_near)
            kind = (dr < cfg.side_very_near) ? CMD_SPIN_LEFT : CMD_VEER_LEFT;
        else
            kind = CMD_CRUISE;

        push_cmd.kind  = kind;
        push_cmd.angle = angle_of(pos_next);
        push_cmd.hold  = cfg.backoff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_tick_reg <= '0;
            pos_reg       <= POS_LEFT;
            up_reg        <= 1'b1;
            dist_reg[0]   <= RST_DISTANCE;
            dist_reg[1]   <= RST_DISTANCE;
            dist_reg[2]   <= RST_DISTANCE;
        end else if (push) begin
            last_tick_reg <= last_tick_next;
            pos_reg       <= pos_next;
            up_reg        <= up_next;
            dist_reg[0]   <= dl;
            dist_reg[1]   <= dc;
            dist_reg[2]   <= dr;
        end
    end

    a_pos_reachable: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("sweep position left the sweep");

    a_tick_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> last_tick_reg == $past(s_now))
        else $error("accepted reading did not update the tick time");

endmodule

// ----- rtl/sso_queue.sv -----
// Short command queue between the front end and the result sequencer.
`timescale 1ns / 1ps
module sso_queue
    import sso_pkg::*;
#(
    parameter int unsigned DEPTH = SSO_QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = push   ? ((wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full command queue");

endmodule

// ----- rtl/sso_back.sv -----
// Back end: expands each command into one or two results behind an output register.
`timescale 1ns / 1ps
module sso_back
    import sso_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output wheels_t            m_wheels,
    output logic [ANGLE_W-1:0] m_angle,
    output logic [HOLD_W-1:0]  m_hold,
    output logic               m_last
);

    logic               valid_reg;
    logic               pend_reg;
    cmd_t               pend_cmd_reg;
    wheels_t            wheels_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [HOLD_W-1:0]  hold_reg;
    logic               last_reg;
    logic               load;

    assign load = !valid_reg || m_ready;
    assign pop  = load && !pend_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else begin
                valid_reg <= q_valid;
                pend_reg  <= q_valid && is_two(q_cmd.kind);
            end
        end
    end

    // Payload: second half of a back-off first, else the queue head
    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                wheels_reg <= wheels_of(pend_cmd_reg.kind, 1'b1);
                angle_reg  <= pend_cmd_reg.angle;
                hold_reg   <= '0;
                last_reg   <= 1'b1;
            end else if (q_valid) begin
                pend_cmd_reg <= q_cmd;
                wheels_reg   <= wheels_of(q_cmd.kind, 1'b0);
                angle_reg    <= q_cmd.angle;
                hold_reg     <= is_two(q_cmd.kind) ? q_cmd.hold : '0;
                last_reg     <= !is_two(q_cmd.kind);
            end
        end
    end

    assign m_valid  = valid_reg;
    assign m_wheels = wheels_reg;
    assign m_angle  = angle_reg;
    assign m_hold   = hold_reg;
    assign m_last   = last_reg;

    a_pend_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> valid_reg && !last_reg)
        else $error("pending turn without a shown reverse command");

    a_pend_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && m_ready |=> valid_reg && last_reg && !pend_reg)
        else $error("turn command did not follow the reverse command");

endmodule

// ----- rtl/sweep_sonar_obstacle_avoider.sv -----
// Top level of the sweep sonar obstacle avoider: config registers, front end, queue, back end.
// An accepted reading is written into the command queue, then loaded into the back end
//   output register; the turn that follows a reverse is loaded once the sink takes the reverse.
// Throughput: one reading per cycle while the queue is not full; a centre-near reading
//   uses the single output register for two transfers, the reverse and then the turn.
// Reset (aresetn low at a clock edge, synchronous): registers to defaults, slots to
//   480, servo at 30 degrees sweeping up, queue and output empty.
`timescale 1ns / 1ps
module sweep_sonar_obstacle_avoider
    import sso_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = SSO_QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write port
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // Readings in
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // now_ms[31:0], distance[47:32]
    // Wheel commands out
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // left_front[12:0], left_back[25:13],
                                           // right_front[38:26], right_back[51:39],
                                           // next_servo_angle[59:52], hold_ms[69:60], zero
    output logic                m_tlast    // last_of_run
);

    cfg_t cfg_reg;

    logic               push;
    cmd_t               push_cmd;
    logic               q_full;
    logic               pop;
    logic               q_valid;
    cmd_t               q_cmd;
    wheels_t            wheels;
    logic [ANGLE_W-1:0] angle;
    logic [HOLD_W-1:0]  hold;

    // Register writes land directly; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tick_period    <= RST_TICK_PERIOD;
            cfg_reg.front_near     <= RST_FRONT_NEAR;
            cfg_reg.side_near      <= RST_SIDE_NEAR;
            cfg_reg.side_very_near <= RST_SIDE_VERY_NEAR;
            cfg_reg.backoff        <= RST_BACKOFF;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TICK_PERIOD:    cfg_reg.tick_period    <= cfg_wdata;
                REG_FRONT_NEAR:     cfg_reg.front_near     <= cfg_wdata;
                REG_SIDE_NEAR:      cfg_reg.side_near      <= cfg_wdata;
                REG_SIDE_VERY_NEAR: cfg_reg.side_very_near <= cfg_wdata;
                REG_BACKOFF:        cfg_reg.backoff        <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end: gate on tick period, store distance, step servo, classify
    sso_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_now    (s_tdata[TIME_W-1:0]),
        .s_dist   (s_tdata[TIME_W+DIST_W-1:TIME_W]),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Decouple classification from result delivery
    sso_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Back end: one transfer per command, two for reverse-then-turn
    sso_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_wheels (wheels),
        .m_angle  (angle),
        .m_hold   (hold),
        .m_last   (m_tlast)
    );

    // Pack result fields, lowest first, zero padded to whole bytes
    assign m_tdata = {2'b00, hold, angle, wheels.rb, wheels.rf, wheels.lb, wheels.lf};

endmodule

// ----- dv/tb_sweep_sonar_obstacle_avoider.sv -----
// Self-checking testbench for the sweep sonar obstacle avoider stream block.
`timescale 1ns / 1ps
module tb_sweep_sonar_obstacle_avoider;
    import sso_pkg::*;

    // Wheel speeds the block may command, 13-bit two's complement
    localparam logic signed [SPEED_W-1:0] V_TURN      = 13'sd1450;
    localparam logic signed [SPEED_W-1:0] V_BACK      = -13'sd1450;
    localparam logic signed [SPEED_W-1:0] V_SPIN      = 13'sd1500;
    localparam logic signed [SPEED_W-1:0] V_SPIN_BACK = -13'sd1500;
    localparam logic signed [SPEED_W-1:0] V_SPIN_IN   = -13'sd1000;
    localparam logic signed [SPEED_W-1:0] V_VEER      = 13'sd2000;
    localparam logic signed [SPEED_W-1:0] V_VEER_IN   = -13'sd500;
    localparam logic signed [SPEED_W-1:0] V_CRUISE    = 13'sd600;

    localparam logic [ANGLE_W-1:0] DEG_LEFT   = 8'd30;
    localparam logic [ANGLE_W-1:0] DEG_CENTRE = 8'd90;
    localparam logic [ANGLE_W-1:0] DEG_RIGHT  = 8'd150;

    // Index with no register behind it; writes there must change nothing
    localparam logic [CFG_A_W-1:0] REG_UNUSED = 3'd7;

    localparam int              LONG_HOLD     = 250;
    localparam int              SETTLE_CYCLES = 8;
    localparam longint unsigned RUN_LIMIT_NS  = 64'd10_000_000;

    typedef struct {
        logic [TIME_W-1:0] now_ms;
        logic [DIST_W-1:0] distance;
    } reading_t;

    typedef struct {
        logic signed [SPEED_W-1:0] lf;
        logic signed [SPEED_W-1:0] lb;
        logic signed [SPEED_W-1:0] rf;
        logic signed [SPEED_W-1:0] rb;
        logic [ANGLE_W-1:0]        angle;
        logic [HOLD_W-1:0]         hold;
        logic                      is_last;
    } wheel_cmd_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // now_ms[31:0], distance[47:32]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // lf[12:0], lb[25:13], rf[38:26], rb[51:39],
                                           // next_servo_angle[59:52], hold_ms[69:60], zero
    logic                m_tlast;          // last_of_run

    // Limits as the block should hold them
    logic [CFG_W-1:0]  lim_tick;
    logic [CFG_W-1:0]  lim_front;
    logic [CFG_W-1:0]  lim_side;
    logic [CFG_W-1:0]  lim_very;
    logic [HOLD_W-1:0] lim_backoff;

    // Predicted sweep state
    logic [TIME_W-1:0] last_tick;
    logic [1:0]        sweep_pos;
    logic              sweep_up;
    logic [DIST_W-1:0] range_slot [3];

    reading_t   reading_q [$];      // readings waiting for the driver
    wheel_cmd_t cmd_expect_q [$];   // commands predicted, not yet seen
    logic [TIME_W-1:0] time_cursor; // timestamp of the last reading meant to be taken
    int fail_cnt = 0;

    logic [DIST_W-1:0] directed_range [20];

    int         src_wait, src_run, src_gap;
    reading_t   src_next;
    int         sink_wait, sink_run, sink_gap, cmd_count;
    wheel_cmd_t mon_want;

    sweep_sonar_obstacle_avoider i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void expect_cmd(input logic signed [SPEED_W-1:0] lf, lb, rf, rb,
                                       input logic [ANGLE_W-1:0] angle,
                                       input logic [HOLD_W-1:0] hold, input logic is_last);
        wheel_cmd_t c;
        c.lf = lf;
        c.lb = lb;
        c.rf = rf;
        c.rb = rb;
        c.angle = angle;
        c.hold = hold;
        c.is_last = is_last;
        cmd_expect_q.push_back(c);
    endfunction

    // Advance the sweep for one reading and queue the commands it causes.
    function automatic void predict_reading(input logic [TIME_W-1:0] now_ms,
                                            input logic [DIST_W-1:0] distance);
        logic [TIME_W-1:0]  elapsed;
        logic [1:0]         slot;
        logic [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]  dl, dc, dr;
        elapsed = now_ms - last_tick;
        // Too soon after the last tick (modulo 2^32): drop the reading
        if (elapsed <= lim_tick)
            return;
        last_tick = now_ms;
        slot = (sweep_pos >= POS_RIGHT) ? POS_RIGHT : sweep_pos;
        range_slot[slot] = distance;
        if (slot == POS_LEFT)
            sweep_up = 1'b1;
        else if (slot == POS_RIGHT)
            sweep_up = 1'b0;
        sweep_pos = sweep_up ? slot + 2'd1 : slot - 2'd1;
        case (sweep_pos)
            POS_LEFT:   angle = DEG_LEFT;
            POS_CENTRE: angle = DEG_CENTRE;
            default:    angle = DEG_RIGHT;
        endcase
        dl = range_slot[POS_LEFT];
        dc = range_slot[POS_CENTRE];
        dr = range_slot[POS_RIGHT];
        if (dc < lim_front) begin
            // Back off, then turn toward the farther side
            expect_cmd(V_BACK, V_BACK, V_BACK, V_BACK, angle, lim_backoff, 1'b0);
            if (dl < dr)
                expect_cmd(V_TURN, V_TURN, V_BACK, V_BACK, angle, '0, 1'b1);
            else
                expect_cmd(V_BACK, V_BACK, V_TURN, V_TURN, angle, '0, 1'b1);
        end else if (dl < lim_side) begin
            if (dl < lim_very)
                expect_cmd(V_SPIN, V_SPIN, V_SPIN_IN, V_SPIN_IN, angle, '0, 1'b1);
            else
                expect_cmd(V_VEER, V_VEER, V_VEER_IN, V_VEER_IN, angle, '0, 1'b1);
        end else if (dr < lim_side) begin
            if (dr < lim_very)
                expect_cmd(V_SPIN_BACK, V_SPIN_BACK, V_SPIN, V_SPIN, angle, '0, 1'b1);
            else
                expect_cmd(V_VEER_IN, V_VEER_IN, V_VEER, V_VEER, angle, '0, 1'b1);
        end else begin
            expect_cmd(V_CRUISE, V_CRUISE, V_CRUISE, V_CRUISE, angle, '0, 1'b1);
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // Gap before the next transfer; zero throughout a no-idle stretch
    function automatic int next_gap(input int run_left);
        return (run_left != 0) ? 0 : $urandom_range(0, 13);
    endfunction

    // Distances cluster on the current thresholds so every branch gets hit
    function automatic logic [DIST_W-1:0] pick_distance();
        logic [DIST_W-1:0] edge_v;
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2, 3:    return DIST_W'($urandom);
            4, 5:    edge_v = lim_front;
            6, 7:    edge_v = lim_side;
            8:       edge_v = lim_very;
            default: return DIST_W'($urandom_range(0, 1200));
        endcase
        return edge_v + DIST_W'($urandom_range(0, 2)) - 1'b1;
    endfunction

    function automatic void push_reading(input logic [TIME_W-1:0] now_ms,
                                         input logic [DIST_W-1:0] distance);
        reading_t r;
        r.now_ms = now_ms;
        r.distance = distance;
        reading_q.push_back(r);
    endfunction

    // Mostly well-spaced readings, some too early, a few at random times.
    task automatic queue_readings(input int count);
        int k;
        logic [TIME_W-1:0] stamp;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0, 1: stamp = time_cursor + $urandom_range(0, lim_tick);
                2: begin
                    // A rejected random stamp stays within one period of the
                    // real last tick, so the next spaced reading is still taken.
                    stamp = $urandom;
                    time_cursor = stamp;
                end
                3, 4, 5, 6, 7, 8: begin
                    stamp = time_cursor + lim_tick + 1 + $urandom_range(0, 2);
                    time_cursor = stamp;
                end
                default: begin
                    stamp = time_cursor + lim_tick + 1 + $urandom_range(0, 5000);
                    time_cursor = stamp;
                end
            endcase
            push_reading(stamp, pick_distance());
        end
    endtask

    // Hold until every reading is in and every command is out, then let
    // dropped readings still in the pipeline clear. Sample on the falling
    // edge so the driver's updates from the rising edge have settled.
    task automatic wait_idle();
        while (reading_q.size() != 0 || s_tvalid || cmd_expect_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_TICK_PERIOD:    lim_tick    = val;
            REG_FRONT_NEAR:     lim_front   = val;
            REG_SIDE_NEAR:      lim_side    = val;
            REG_SIDE_VERY_NEAR: lim_very    = val;
            REG_BACKOFF:        lim_backoff = val[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] tick, front, side, very, backoff);
        wait_idle();
        write_reg(REG_TICK_PERIOD, tick);
        write_reg(REG_FRONT_NEAR, front);
        write_reg(REG_SIDE_NEAR, side);
        write_reg(REG_SIDE_VERY_NEAR, very);
        write_reg(REG_BACKOFF, backoff);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Driver: offer queued readings with random gaps and predict on each transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
            src_run  <= 0;
        end else if (s_tvalid && s_tready) begin
            predict_reading(s_tdata[TIME_W-1:0], s_tdata[S_DATA_W-1:TIME_W]);
            src_gap = next_gap(src_run);
            src_run <= (src_run != 0) ? src_run - 1 : (($urandom_range(0, 39) == 0) ? 30 : 0);
            if (src_gap == 0 && reading_q.size() != 0) begin
                // Keep tvalid high and move straight on to the next reading
                src_next = reading_q.pop_front();
                s_tdata <= {src_next.distance, src_next.now_ms};
            end else begin
                s_tvalid <= 1'b0;
                src_wait <= src_gap;
            end
        end else if (!s_tvalid) begin
            if (src_wait != 0) begin
                src_wait <= src_wait - 1;
            end else if (reading_q.size() != 0) begin
                src_next = reading_q.pop_front();
                s_tdata  <= {src_next.distance, src_next.now_ms};
                s_tvalid <= 1'b1;
            end
        end
    end

    // Sink: drop tready for a random gap after each transfer; twice hold off
    // long enough for the block to fill and stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
            sink_run  <= 0;
            cmd_count <= 0;
        end else if (m_tvalid && m_tready) begin
            cmd_count <= cmd_count + 1;
            sink_gap = (cmd_count == 300 || cmd_count == 900) ? LONG_HOLD : next_gap(sink_run);
            sink_run <= (sink_run != 0) ? sink_run - 1 : (($urandom_range(0, 39) == 0) ? 30 : 0);
            if (sink_gap != 0) begin
                m_tready  <= 1'b0;
                sink_wait <= sink_gap;
            end
        end else if (!m_tready) begin
            if (sink_wait != 0)
                sink_wait <= sink_wait - 1;
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: compare each command transfer with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cmd_expect_q.size() == 0) begin
                $error("unexpected command: tdata %h tlast %b", m_tdata, m_tlast);
                fail_cnt++;
            end else begin
                mon_want = cmd_expect_q.pop_front();
                check_field("left_front_speed", mon_want.lf, $signed(m_tdata[12:0]));
                check_field("left_back_speed", mon_want.lb, $signed(m_tdata[25:13]));
                check_field("right_front_speed", mon_want.rf, $signed(m_tdata[38:26]));
                check_field("right_back_speed", mon_want.rb, $signed(m_tdata[51:39]));
                check_field("next_servo_angle", mon_want.angle, m_tdata[59:52]);
                check_field("hold_ms", mon_want.hold, m_tdata[69:60]);
                check_field("tdata_pad", 0, m_tdata[M_DATA_W-1:70]);
                check_field("last_of_run", mon_want.is_last, m_tlast);
            end
        end
    end

    initial begin
        lim_tick    = RST_TICK_PERIOD;
        lim_front   = RST_FRONT_NEAR;
        lim_side    = RST_SIDE_NEAR;
        lim_very    = RST_SIDE_VERY_NEAR;
        lim_backoff = RST_BACKOFF;
        last_tick   = '0;
        sweep_pos   = POS_LEFT;
        sweep_up    = 1'b1;
        range_slot[0] = RST_DISTANCE;
        range_slot[1] = RST_DISTANCE;
        range_slot[2] = RST_DISTANCE;

        // Walk the sweep (left, centre, right, centre, ...) through cruise,
        // reverse with both turn directions, veer and spin on each side, and
        // the threshold edges, all with the reset limits.
        directed_range = '{16'hFFFF, 16'd479, 16'd0, 16'd480, 16'd319, 16'd5000, 16'd159,
                           16'd5000, 16'd159, 16'd5000, 16'd319, 16'd5000, 16'd1000, 16'd0,
                           16'd2000, 16'd5000, 16'd320, 16'd479, 16'd160, 16'd480};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Elapsed equal to the period: dropped
        push_reading(TIME_W'(RST_TICK_PERIOD), 16'h5A5A);
        time_cursor = 32'd201;
        for (int i = 0; i < 20; i++) begin
            // Jump to the top of the time range so the next step wraps past zero
            if (i == 10)
                time_cursor = 32'hFFFF_FF80;
            else if (i != 0)
                time_cursor = time_cursor + 201;
            push_reading(time_cursor, directed_range[i]);
            // Same stamp again: no time has passed, drop it
            if (i == 5)
                push_reading(time_cursor, 16'hA5A5);
        end

        // Extremes first, then a middle setting and two random ones
        set_limits(16'd0, 16'd480, 16'd320, 16'd160, 16'd0);
        queue_readings(238);
        set_limits(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'h03FF);
        queue_readings(238);
        set_limits(16'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFE00);   // backoff keeps low 10 bits
        queue_readings(238);
        set_limits(16'd200, 16'd1000, 16'd2000, 16'd800, 16'd100);
        queue_readings(238);
        repeat (2) begin
            set_limits(CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom),
                       CFG_W'($urandom_range(0, 3000)), CFG_W'($urandom_range(0, 1500)),
                       CFG_W'($urandom));
            queue_readings(238);
        end

        wait_idle();
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
